// File: src/lgm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgm_pkg: shared types and constants of the link gene mutator
// Widths of the link word, the bit position and the result queue, plus the
// structs that travel between the link builder, the result queue and the top.
// ----------------------------------------------------------------------------
package lgm_pkg;

    localparam int LINK_W      = 63;
    localparam int ALEN_W      = 5;
    localparam int POS_W       = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [ALEN_W-1:0] ADDR_LEN_RESET = ALEN_W'(8);

    // Number of words that one gene bit pushes into the result queue.
    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE  = 2'd1;
    localparam logic [1:0] PUSH_TWO  = 2'd2;

    typedef struct packed {
        logic [LINK_W-1:0] link_word;
        logic              copy_valid;
        logic              last_of_run;
        logic              chromosome_end;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              nearly_full;
    } t_queue_status;

endpackage

// File: src/link_gene_mutator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_gene_mutator: link-wise mutation of a chromosome bit stream
// Groups gene bits into links, applies flip draws and drops or repeats links.
// ----------------------------------------------------------------------------
// The block takes one gene bit per cycle and emits one word per completed
// link (two when the link is repeated, none when it is dropped; a link drawn
// for both gives one; a dropped final link gives an end marker), with the
// first gene in bit 0 of o_link_word. Words are written into a four-entry
// queue by the gene bit that ends their link; input is stalled only while
// more than two words are queued. With a downstream that never stalls, the
// block sustains one gene bit per cycle while the stream averages at most
// one word per gene bit; repeated links of one bit make two words per bit,
// so the output's single word per cycle then holds the input to that rate.
// The address length register sets links of 2*address_length+1 bits and is
// meant to be written between chromosomes.
// ----------------------------------------------------------------------------
module link_gene_mutator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lgm_pkg::ALEN_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_gene_bit,
    input  logic                        i_flip_first,
    input  logic                        i_flip_second,
    input  logic                        i_drop_draw,
    input  logic                        i_repeat_draw,
    input  logic                        i_source_end,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [lgm_pkg::LINK_W-1:0]  o_link_word,
    output logic                        o_copy_valid,
    output logic                        o_last_of_run,
    output logic                        o_chromosome_end
);

    logic [lgm_pkg::ALEN_W-1:0] r_addr_len;
    logic                       in_accept;
    lgm_pkg::t_push             push;
    lgm_pkg::t_result           head;
    lgm_pkg::t_queue_status     q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_len <= lgm_pkg::ADDR_LEN_RESET;
        end else if (i_cfg_we) begin
            r_addr_len <= i_cfg_data;
        end
    end

    assign o_stall   = q_status.nearly_full;
    assign in_accept = i_valid && !o_stall;

    lgm_link_builder u_builder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_addr_len   (r_addr_len),
        .i_gene_bit   (i_gene_bit),
        .i_flip_first (i_flip_first),
        .i_flip_second(i_flip_second),
        .i_drop_draw  (i_drop_draw),
        .i_repeat_draw(i_repeat_draw),
        .i_source_end (i_source_end),
        .o_push       (push)
    );

    lgm_result_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pop      (!i_stall),
        .o_head     (head),
        .o_not_empty(o_valid),
        .o_status   (q_status)
    );

    assign o_link_word      = head.link_word;
    assign o_copy_valid     = head.copy_valid;
    assign o_last_of_run    = head.last_of_run;
    assign o_chromosome_end = head.chromosome_end;

    // The queue never holds more words than it has entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= lgm_pkg::QCNT_W'(lgm_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // The end of a chromosome is always the last word of its run.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_chromosome_end |-> o_last_of_run)
        else $error("chromosome end without last of run");

    // An end marker carries no copy and is only produced at the chromosome end.
    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_copy_valid |-> o_chromosome_end && (o_link_word == '0))
        else $error("malformed end marker");

    // Nothing is pushed unless a gene bit is accepted.
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |-> push.count == lgm_pkg::PUSH_NONE)
        else $error("word pushed without an accepted gene bit");

endmodule

// File: src/lgm_link_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgm_link_builder: collects gene bits into links and decides their fate
// Holds the two mutated copies of the current link, the bit position and the
// drop and repeat draws of the link's first bit; at a link end it hands zero,
// one or two result words to the result queue.
// ----------------------------------------------------------------------------
module lgm_link_builder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [lgm_pkg::ALEN_W-1:0] i_addr_len,
    input  logic                       i_gene_bit,
    input  logic                       i_flip_first,
    input  logic                       i_flip_second,
    input  logic                       i_drop_draw,
    input  logic                       i_repeat_draw,
    input  logic                       i_source_end,
    output lgm_pkg::t_push             o_push
);

    logic [lgm_pkg::POS_W-1:0]  r_pos, n_pos;
    logic                       r_drop, n_drop;
    logic                       r_repeat, n_repeat;
    logic [lgm_pkg::LINK_W-1:0] r_first, n_first;
    logic [lgm_pkg::LINK_W-1:0] r_second, n_second;

    logic                       pos_zero;
    logic                       drop_eff;
    logic                       repeat_eff;
    logic                       link_done;
    logic [lgm_pkg::POS_W-1:0]  last_index;
    logic [lgm_pkg::LINK_W-1:0] bit_mask;
    logic [lgm_pkg::LINK_W-1:0] word_first;
    logic [lgm_pkg::LINK_W-1:0] word_second;

    assign pos_zero   = (r_pos == '0);
    assign drop_eff   = pos_zero ? i_drop_draw   : r_drop;
    assign repeat_eff = pos_zero ? i_repeat_draw : r_repeat;
    assign last_index = {i_addr_len, 1'b0};
    // A register write in the middle of a link can leave the position past the end.
    assign link_done  = (r_pos >= last_index) || i_source_end;
    assign bit_mask   = lgm_pkg::LINK_W'(1) << r_pos;

    assign word_first  = (pos_zero ? '0 : r_first)
                       | ((i_gene_bit ^ i_flip_first) ? bit_mask : '0);
    assign word_second = (pos_zero ? '0 : r_second)
                       | ((i_gene_bit ^ i_flip_second) ? bit_mask : '0);

    always_comb begin
        n_pos    = r_pos;
        n_drop   = r_drop;
        n_repeat = r_repeat;
        n_first  = r_first;
        n_second = r_second;
        o_push   = '0;
        if (i_accept) begin
            n_drop   = drop_eff;
            n_repeat = repeat_eff;
            n_first  = word_first;
            n_second = word_second;
            if (link_done) begin
                n_pos = '0;
                if (drop_eff && !repeat_eff) begin
                    // A dropped final link still marks the chromosome end.
                    if (i_source_end) begin
                        o_push.count                = lgm_pkg::PUSH_ONE;
                        o_push.first.link_word      = '0;
                        o_push.first.copy_valid     = 1'b0;
                        o_push.first.last_of_run    = 1'b1;
                        o_push.first.chromosome_end = 1'b1;
                    end
                end else if (!drop_eff && repeat_eff) begin
                    o_push.count                 = lgm_pkg::PUSH_TWO;
                    o_push.first.link_word       = word_first;
                    o_push.first.copy_valid      = 1'b1;
                    o_push.first.last_of_run     = 1'b0;
                    o_push.first.chromosome_end  = 1'b0;
                    o_push.second.link_word      = word_second;
                    o_push.second.copy_valid     = 1'b1;
                    o_push.second.last_of_run    = 1'b1;
                    o_push.second.chromosome_end = i_source_end;
                end else begin
                    o_push.count                = lgm_pkg::PUSH_ONE;
                    o_push.first.link_word      = word_first;
                    o_push.first.copy_valid     = 1'b1;
                    o_push.first.last_of_run    = 1'b1;
                    o_push.first.chromosome_end = i_source_end;
                end
            end else begin
                n_pos = r_pos + lgm_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_drop   <= 1'b0;
            r_repeat <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_drop   <= n_drop;
            r_repeat <= n_repeat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_second <= n_second;
    end

endmodule

// File: src/lgm_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgm_result_queue: small queue of result words in front of the output
// Takes up to two words per cycle and, while i_pop is high, delivers one word
// per cycle; it reports nearly full when fewer than two free entries remain.
// ----------------------------------------------------------------------------
module lgm_result_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lgm_pkg::t_push        i_push,
    input  logic                  i_pop,
    output lgm_pkg::t_result      o_head,
    output logic                  o_not_empty,
    output lgm_pkg::t_queue_status o_status
);

    lgm_pkg::t_result r_entry [lgm_pkg::QUEUE_DEPTH];

    logic [lgm_pkg::QPTR_W-1:0] r_rd, n_rd;
    logic [lgm_pkg::QPTR_W-1:0] r_wr, n_wr;
    logic [lgm_pkg::QCNT_W-1:0] r_cnt, n_cnt;
    logic [lgm_pkg::QPTR_W-1:0] wr_next;
    logic                       do_pop;

    assign do_pop  = i_pop && (r_cnt != '0);
    assign wr_next = r_wr + lgm_pkg::QPTR_W'(1);

    always_comb begin
        n_rd  = do_pop ? r_rd + lgm_pkg::QPTR_W'(1) : r_rd;
        n_wr  = r_wr + lgm_pkg::QPTR_W'(i_push.count);
        n_cnt = r_cnt + lgm_pkg::QCNT_W'(i_push.count)
              - lgm_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != lgm_pkg::PUSH_NONE) begin
            r_entry[r_wr] <= i_push.first;
        end
        if (i_push.count == lgm_pkg::PUSH_TWO) begin
            r_entry[wr_next] <= i_push.second;
        end
    end

    assign o_head               = r_entry[r_rd];
    assign o_not_empty          = (r_cnt != '0);
    assign o_status.count       = r_cnt;
    assign o_status.nearly_full = (r_cnt > lgm_pkg::QCNT_W'(lgm_pkg::QUEUE_DEPTH - 2));

endmodule
